// ----- rtl/core/flba_pkg.sv -----
// ---------------------------------------------------------------------------
// flba_pkg
// Shared types and constants of the free-list / bump allocator core.
// ---------------------------------------------------------------------------
package flba_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BASE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HDR   = 4'd3;

    localparam logic [31:0] ARENA_BASE_RST = 32'd65536;
    localparam logic [20:0] PAGE_BYTES_RST = 21'd4096;
    localparam logic [8:0]  HEADER_RST     = 9'd8;
    localparam logic [8:0]  FIRST_HDR_RST  = 9'd64;

    localparam logic        MODE_ALLOC = 1'b0;
    localparam logic        MODE_FREE  = 1'b1;

    localparam logic [1:0]  ST_OK        = 2'd0;
    localparam logic [1:0]  ST_EXHAUSTED = 2'd1;
    localparam logic [1:0]  ST_STACK_FULL = 2'd2;
    localparam logic [1:0]  ST_BAD_FREE  = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [12:0] elem_bytes;
        logic [3:0]  align_log2;
        logic [31:0] free_addr;
    } fl_req_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  status;
        logic [31:0] live_count;
        logic [31:0] peak_count;
        logic [8:0]  pages_in_use;
    } fl_rsp_t;

    typedef struct packed {
        logic load_req;
        logic align_en;
        logic fit_en;
        logic commit;
    } fl_cmd_t;

endpackage

// ----- rtl/core/flba_ctrl.sv -----
// ---------------------------------------------------------------------------
// flba_ctrl
// Request sequencer: accept, align, fit check, commit into the result register.
// ---------------------------------------------------------------------------
module flba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output flba_pkg::fl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALIGN,
        S_FIT,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   commit;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign commit  = (state_reg == S_COMMIT) && (!m_valid_reg || m_ready);

    assign cmd.load_req = s_valid && s_ready;
    assign cmd.align_en = (state_reg == S_ALIGN);
    assign cmd.fit_en   = (state_reg == S_FIT);
    assign cmd.commit   = commit;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_ALIGN;
                end
            end
            S_ALIGN:  state_next = S_FIT;
            S_FIT:    state_next = S_COMMIT;
            S_COMMIT: begin
                if (commit) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/core/flba_datapath.sv -----
// ---------------------------------------------------------------------------
// flba_datapath
// Configuration, allocator state, free stack memory and result register.
// ---------------------------------------------------------------------------
module flba_datapath #(
    parameter int FREE_DEPTH = 256,
    parameter int MAX_PAGES  = 256,
    parameter int ADDR_BITS  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [flba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [flba_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  flba_pkg::fl_req_t                 req,
    input  flba_pkg::fl_cmd_t                 cmd,
    output flba_pkg::fl_rsp_t                 rsp
);

    // positions never exceed 2^39, so 40 bits hold them exactly
    localparam int PW  = (ADDR_BITS + 1 > 40) ? ADDR_BITS + 1 : 40;
    localparam int SW  = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int DW  = $clog2(FREE_DEPTH + 1);
    localparam int PCW = $clog2(MAX_PAGES + 1);
    localparam logic [PW-1:0]  ADDR_TOP  = PW'(1) << ADDR_BITS;
    localparam logic [DW-1:0]  DEPTH_MAX = DW'(FREE_DEPTH);
    localparam logic [PCW-1:0] PAGE_MAX  = PCW'(MAX_PAGES);

    logic [31:0]     arena_reg, arena_next;
    logic [20:0]     page_reg, page_next;
    logic [8:0]      hdr_reg, hdr_next;
    logic [8:0]      fhdr_reg, fhdr_next;

    logic [DW-1:0]   depth_reg, depth_next;
    logic [PW-1:0]   bump_reg, bump_next;
    logic [PW-1:0]   limit_reg, limit_next;
    logic [PCW-1:0]  pages_reg, pages_next;
    logic [31:0]     live_reg, live_next;
    logic [31:0]     peak_reg, peak_next;

    flba_pkg::fl_req_t req_reg;
    flba_pkg::fl_rsp_t rsp_reg, rsp_next;

    logic [PW-1:0]   a_bump_reg, a_page_reg, new_limit_reg;
    logic [PW-1:0]   end_bump_reg, end_page_reg;
    logic            fit_bump_reg, fit_page_reg;

    logic [PW-1:0]   mask, page_base, elem_w, end_bump, end_page;
    logic [31:0]     stack_mem [FREE_DEPTH];
    logic [31:0]     pop_data_reg;
    logic [DW-1:0]   depth_m1;
    logic            push_en;
    logic [31:0]     live_inc;

    // configuration write view
    always_comb begin
        arena_next = arena_reg;
        page_next  = page_reg;
        hdr_next   = hdr_reg;
        fhdr_next  = fhdr_reg;
        case (cfg_index)
            flba_pkg::CFG_ARENA_BASE: arena_next = cfg_wdata;
            flba_pkg::CFG_PAGE_BYTES: page_next  = cfg_wdata[20:0];
            flba_pkg::CFG_HEADER:     hdr_next   = cfg_wdata[8:0];
            flba_pkg::CFG_FIRST_HDR:  fhdr_next  = cfg_wdata[8:0];
            default: ;
        endcase
    end

    // alignment and fit
    assign mask      = (PW'(1) << req_reg.align_log2) - PW'(1);
    assign page_base = limit_reg + PW'(hdr_reg);
    assign elem_w    = PW'(req_reg.elem_bytes);
    assign end_bump  = a_bump_reg + elem_w;
    assign end_page  = a_page_reg + elem_w;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= req;
        end
        if (cmd.align_en) begin
            a_bump_reg    <= (bump_reg + mask) & ~mask;
            a_page_reg    <= (page_base + mask) & ~mask;
            new_limit_reg <= limit_reg + PW'(page_reg);
        end
        if (cmd.fit_en) begin
            end_bump_reg <= end_bump;
            end_page_reg <= end_page;
            fit_bump_reg <= (end_bump <= limit_reg) && (a_bump_reg < ADDR_TOP)
                            && (end_bump <= ADDR_TOP);
            fit_page_reg <= (end_page <= new_limit_reg) && (a_page_reg < ADDR_TOP)
                            && (end_page <= ADDR_TOP);
        end
    end

    // free stack
    assign depth_m1 = depth_reg - DW'(1);
    assign push_en  = cmd.commit && (req_reg.mode == flba_pkg::MODE_FREE)
                      && (req_reg.free_addr != 32'd0) && (live_reg != 32'd0)
                      && (depth_reg < DEPTH_MAX);

    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[depth_reg[SW-1:0]] <= req_reg.free_addr;
        end
        pop_data_reg <= stack_mem[depth_m1[SW-1:0]];
    end

    // commit
    assign live_inc = (live_reg == 32'hFFFF_FFFF) ? live_reg : live_reg + 32'd1;

    always_comb begin
        depth_next = depth_reg;
        bump_next  = bump_reg;
        limit_next = limit_reg;
        pages_next = pages_reg;
        live_next  = live_reg;
        peak_next  = peak_reg;
        rsp_next.addr   = 32'd0;
        rsp_next.status = flba_pkg::ST_OK;
        if (req_reg.mode == flba_pkg::MODE_ALLOC) begin
            if (depth_reg != DW'(0)) begin
                depth_next    = depth_m1;
                rsp_next.addr = pop_data_reg;
                live_next     = live_inc;
            end else if (fit_bump_reg) begin
                rsp_next.addr = a_bump_reg[31:0];
                bump_next     = end_bump_reg;
                live_next     = live_inc;
                if (live_inc > peak_reg) begin
                    peak_next = live_inc;
                end
            end else if ((pages_reg >= PAGE_MAX) || !fit_page_reg) begin
                rsp_next.status = flba_pkg::ST_EXHAUSTED;
            end else begin
                rsp_next.addr = a_page_reg[31:0];
                bump_next     = end_page_reg;
                limit_next    = new_limit_reg;
                pages_next    = pages_reg + PCW'(1);
                live_next     = live_inc;
                if (live_inc > peak_reg) begin
                    peak_next = live_inc;
                end
            end
        end else begin
            if ((req_reg.free_addr == 32'd0) || (live_reg == 32'd0)) begin
                rsp_next.status = flba_pkg::ST_BAD_FREE;
            end else if (depth_reg >= DEPTH_MAX) begin
                rsp_next.status = flba_pkg::ST_STACK_FULL;
            end else begin
                depth_next = depth_reg + DW'(1);
                live_next  = live_reg - 32'd1;
            end
        end
        rsp_next.live_count   = live_next;
        rsp_next.peak_count   = peak_next;
        rsp_next.pages_in_use = 9'(pages_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arena_reg <= flba_pkg::ARENA_BASE_RST;
            page_reg  <= flba_pkg::PAGE_BYTES_RST;
            hdr_reg   <= flba_pkg::HEADER_RST;
            fhdr_reg  <= flba_pkg::FIRST_HDR_RST;
            depth_reg <= '0;
            bump_reg  <= PW'(flba_pkg::ARENA_BASE_RST) + PW'(flba_pkg::FIRST_HDR_RST);
            limit_reg <= PW'(flba_pkg::ARENA_BASE_RST) + PW'(flba_pkg::PAGE_BYTES_RST);
            pages_reg <= PCW'(1);
            live_reg  <= '0;
            peak_reg  <= '0;
        end else if (cfg_we && (cfg_index <= flba_pkg::CFG_FIRST_HDR)) begin
            arena_reg <= arena_next;
            page_reg  <= page_next;
            hdr_reg   <= hdr_next;
            fhdr_reg  <= fhdr_next;
            depth_reg <= '0;
            bump_reg  <= PW'(arena_next) + PW'(fhdr_next);
            limit_reg <= PW'(arena_next) + PW'(page_next);
            pages_reg <= PCW'(1);
            live_reg  <= '0;
            peak_reg  <= '0;
        end else if (cmd.commit) begin
            depth_reg <= depth_next;
            bump_reg  <= bump_next;
            limit_reg <= limit_next;
            pages_reg <= pages_next;
            live_reg  <= live_next;
            peak_reg  <= peak_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ----- rtl/core/free_list_bump_allocator_core.sv -----
// ---------------------------------------------------------------------------
// free_list_bump_allocator_core
// Each request steps through accept, align, fit check and commit, in order;
// a new one is accepted only when idle; commit waits while a result is held.
// The result register frees the input side while a result waits.
// Reset restores default configuration, page 1, empty free stack, zero counts;
// a config write to index 0-3 restarts the allocator from the new settings.
// ---------------------------------------------------------------------------
module free_list_bump_allocator_core #(
    parameter int FREE_DEPTH = 256,
    parameter int MAX_PAGES  = 256,
    parameter int ADDR_BITS  = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  flba_pkg::fl_req_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output flba_pkg::fl_rsp_t               m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [flba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [flba_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    flba_pkg::fl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    flba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    flba_datapath #(
        .FREE_DEPTH (FREE_DEPTH),
        .MAX_PAGES  (MAX_PAGES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (s_data),
        .cmd       (cmd),
        .rsp       (m_data)
    );

endmodule
